// File: rtl/ltl_tok_pkg.sv
// Shared types, character codes and helper functions for the LTL formula tokenizer.
// Used by ltl_tok_core, ltl_tok_outq and ltl_formula_tokenizer_top. No dependencies.
package ltl_tok_pkg;

    // Default limits for the saturating length and position counters.
    localparam int LENGTH_LIMIT_DEF   = 255;
    localparam int POSITION_LIMIT_DEF = 65535;

    // Fixed field widths of a result item.
    localparam int KIND_W    = 5;
    localparam int VALUE_W   = 31;
    localparam int START_W   = 16;
    localparam int LEN_OUT_W = 8;

    localparam logic [VALUE_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // What is held while the next character decides the token.
    typedef enum logic [3:0] {
        M_IDLE,
        M_ID,
        M_NUM,
        M_MINUS,
        M_SLASH,
        M_BSLASH,
        M_LBRACK,
        M_LESS,
        M_GREATER
    } mode_t;

    // Partial match of an identifier against tt and ff.
    typedef enum logic [2:0] {
        B_NONE,
        B_T,
        B_TT,
        B_F,
        B_FF
    } bmatch_t;

    typedef enum logic [KIND_W-1:0] {
        K_END        = 5'd0,
        K_ID         = 5'd1,
        K_BOOL       = 5'd2,
        K_DIGITS     = 5'd3,
        K_NOT        = 5'd4,
        K_UNTIL      = 5'd5,
        K_RELEASE    = 5'd6,
        K_NEXT       = 5'd7,
        K_AND        = 5'd8,
        K_OR         = 5'd9,
        K_LPAREN     = 5'd10,
        K_RPAREN     = 5'd11,
        K_EQ         = 5'd12,
        K_PLUS       = 5'd13,
        K_MINUS      = 5'd14,
        K_IMPLIES    = 5'd15,
        K_WEDGE      = 5'd16,
        K_VEE        = 5'd17,
        K_ALWAYS     = 5'd18,
        K_EVENTUALLY = 5'd19,
        K_LT         = 5'd20,
        K_LE         = 5'd21,
        K_GT         = 5'd22,
        K_GE         = 5'd23,
        K_UNKNOWN    = 5'd24
    } kind_t;

    // One result item.
    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic                 ovf;
        logic                 bval;
        logic [START_W-1:0]   start;
        logic [LEN_OUT_W-1:0] len;
        logic                 last;
    } tok_res_t;

    // Results produced by one step, handed to the output queue.
    typedef struct packed {
        logic [1:0] cnt;
        tok_res_t   res0;
        tok_res_t   res1;
    } tok_push_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Token of an undecided operator prefix when its partner does not follow.
    function automatic kind_t single_kind(input mode_t m);
        kind_t k;
        case (m)
            M_MINUS:   k = K_MINUS;
            M_LESS:    k = K_LT;
            M_GREATER: k = K_GT;
            default:   k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // Two-character operator formed by the pending prefix and c; K_END if none.
    function automatic kind_t pair_kind(input mode_t m, input logic [7:0] c);
        kind_t k;
        k = K_END;
        case (m)
            M_MINUS:   if (c == CH_GT) k = K_IMPLIES;
            M_SLASH:   if (c == CH_BSLASH) k = K_WEDGE;
            M_BSLASH:  if (c == CH_SLASH) k = K_VEE;
            M_LBRACK:  if (c == CH_RBRACK) k = K_ALWAYS;
            M_LESS:
            begin
                if (c == CH_GT)
                    k = K_EVENTUALLY;
                else if (c == CH_EQ)
                    k = K_LE;
            end
            M_GREATER: if (c == CH_EQ) k = K_GE;
            default:   k = K_END;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/ltl_tok_core.sv
// Tokenizer state registers and the single-step scan logic for one character.
// Depends on ltl_tok_pkg.
module ltl_tok_core
    import ltl_tok_pkg::*;
#(
    parameter int LENGTH_LIMIT   = LENGTH_LIMIT_DEF,
    parameter int POSITION_LIMIT = POSITION_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    output tok_push_t  push
);

    localparam int LW = $clog2(LENGTH_LIMIT + 1);
    localparam int PW = $clog2(POSITION_LIMIT + 1);

    mode_t              mode_reg, mode_next;
    bmatch_t            bm_reg, bm_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic [LW-1:0]      run_len_reg, run_len_next;
    logic [PW-1:0]      run_start_reg, run_start_next;
    logic [PW-1:0]      pos_reg, pos_next;

    logic               eot;
    logic               pend;
    logic               cont;
    logic               pair;
    kind_t              pk;
    mode_t              fresh_mode;
    kind_t              fresh_kind;
    logic               fresh_emit;
    logic [34:0]        acc_x10;
    logic               acc_over;
    logic [LW-1:0]      run_len_inc;
    logic [PW-1:0]      pos_inc;
    tok_res_t           flush_res;
    tok_res_t           fresh_res;
    tok_res_t           pair_res;
    tok_res_t           end_res;

    // Classification of the current character against the pending token.
    assign eot  = end_of_text || (ch == CH_NUL);
    assign pend = (mode_reg != M_IDLE);
    assign pk   = pair_kind(mode_reg, ch);
    assign pair = (pk != K_END);
    assign cont = ((mode_reg == M_ID) && (is_letter(ch) || is_digit(ch)))
               || ((mode_reg == M_NUM) && is_digit(ch));

    // Saturating counters.
    assign run_len_inc = (run_len_reg < LW'(LENGTH_LIMIT)) ? run_len_reg + 1'b1 : run_len_reg;
    assign pos_inc     = (pos_reg < PW'(POSITION_LIMIT)) ? pos_reg + 1'b1 : pos_reg;

    // Decimal accumulate: acc * 10 + digit, checked against the saturation limit.
    assign acc_x10  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {31'd0, ch[3:0]};
    assign acc_over = (acc_x10 > {4'd0, NUM_MAX});

    // How the character is scanned when nothing is pending.
    always_comb
    begin
        fresh_mode = M_IDLE;
        fresh_kind = K_UNKNOWN;
        fresh_emit = 1'b0;
        if (!is_space(ch))
        begin
            if (is_letter(ch) && ch != CH_X && ch != CH_U && ch != CH_R)
            begin
                fresh_mode = M_ID;
            end
            else if (is_digit(ch))
            begin
                fresh_mode = M_NUM;
            end
            else
            begin
                case (ch)
                    CH_MINUS:  fresh_mode = M_MINUS;
                    CH_SLASH:  fresh_mode = M_SLASH;
                    CH_BSLASH: fresh_mode = M_BSLASH;
                    CH_LBRACK: fresh_mode = M_LBRACK;
                    CH_LT:     fresh_mode = M_LESS;
                    CH_GT:     fresh_mode = M_GREATER;
                    CH_BANG:   fresh_kind = K_NOT;
                    CH_U:      fresh_kind = K_UNTIL;
                    CH_R:      fresh_kind = K_RELEASE;
                    CH_X:      fresh_kind = K_NEXT;
                    CH_AMP:    fresh_kind = K_AND;
                    CH_BAR:    fresh_kind = K_OR;
                    CH_LPAREN: fresh_kind = K_LPAREN;
                    CH_RPAREN: fresh_kind = K_RPAREN;
                    CH_EQ:     fresh_kind = K_EQ;
                    CH_PLUS:   fresh_kind = K_PLUS;
                    default:   fresh_kind = K_UNKNOWN;
                endcase
                fresh_emit = (fresh_mode == M_IDLE);
            end
        end
    end

    // Candidate result items.
    always_comb
    begin
        flush_res       = '0;
        flush_res.start = START_W'(run_start_reg);
        flush_res.len   = LEN_OUT_W'(1);
        case (mode_reg)
            M_ID:
            begin
                flush_res.len = LEN_OUT_W'(run_len_reg);
                if (bm_reg == B_TT || bm_reg == B_FF)
                begin
                    flush_res.kind = K_BOOL;
                    flush_res.bval = (bm_reg == B_TT);
                end
                else
                begin
                    flush_res.kind = K_ID;
                end
            end
            M_NUM:
            begin
                flush_res.kind  = K_DIGITS;
                flush_res.value = acc_reg;
                flush_res.ovf   = sat_reg;
                flush_res.len   = LEN_OUT_W'(run_len_reg);
            end
            default:
            begin
                flush_res.kind = single_kind(mode_reg);
            end
        endcase

        fresh_res       = '0;
        fresh_res.kind  = fresh_kind;
        fresh_res.start = START_W'(pos_reg);
        fresh_res.len   = LEN_OUT_W'(1);
        fresh_res.last  = 1'b1;

        pair_res        = '0;
        pair_res.kind   = pk;
        pair_res.start  = START_W'(run_start_reg);
        pair_res.len    = LEN_OUT_W'(2);
        pair_res.last   = 1'b1;

        end_res         = '0;
        end_res.kind    = K_END;
        end_res.start   = START_W'(pos_reg);
        end_res.last    = 1'b1;
    end

    // Result selection for this step.
    always_comb
    begin
        push.cnt  = 2'd0;
        push.res0 = flush_res;
        push.res1 = end_res;
        if (eot)
        begin
            if (pend)
            begin
                push.cnt = 2'd2;
            end
            else
            begin
                push.res0 = end_res;
                push.cnt  = 2'd1;
            end
        end
        else if (cont)
        begin
            push.cnt = 2'd0;
        end
        else if (pair)
        begin
            push.res0 = pair_res;
            push.cnt  = 2'd1;
        end
        else if (pend && fresh_emit)
        begin
            push.res1 = fresh_res;
            push.cnt  = 2'd2;
        end
        else if (pend)
        begin
            push.res0.last = 1'b1;
            push.cnt       = 2'd1;
        end
        else if (fresh_emit)
        begin
            push.res0 = fresh_res;
            push.cnt  = 2'd1;
        end
        if (!step_en)
        begin
            push.cnt = 2'd0;
        end
    end

    // Next tokenizer state.
    always_comb
    begin
        mode_next      = mode_reg;
        bm_next        = bm_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        pos_next       = pos_inc;
        if (eot)
        begin
            mode_next      = M_IDLE;
            bm_next        = B_NONE;
            acc_next       = '0;
            sat_next       = 1'b0;
            run_len_next   = '0;
            run_start_next = '0;
            pos_next       = '0;
        end
        else if (cont)
        begin
            run_len_next = run_len_inc;
            if (mode_reg == M_ID)
            begin
                if (bm_reg == B_T && ch == CH_LO_T)
                    bm_next = B_TT;
                else if (bm_reg == B_F && ch == CH_LO_F)
                    bm_next = B_FF;
                else
                    bm_next = B_NONE;
            end
            else if (!sat_reg)
            begin
                if (acc_over)
                begin
                    acc_next = NUM_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_x10[VALUE_W-1:0];
                end
            end
        end
        else if (pair)
        begin
            mode_next = M_IDLE;
        end
        else
        begin
            mode_next = fresh_mode;
            if (fresh_mode != M_IDLE)
            begin
                run_start_next = pos_reg;
                run_len_next   = LW'(1);
            end
            if (fresh_mode == M_ID)
            begin
                if (ch == CH_LO_T)
                    bm_next = B_T;
                else if (ch == CH_LO_F)
                    bm_next = B_F;
                else
                    bm_next = B_NONE;
            end
            if (fresh_mode == M_NUM)
            begin
                acc_next = {27'd0, ch[3:0]};
                sat_next = 1'b0;
            end
        end
    end

    // State registers advance once per consumed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            bm_reg        <= B_NONE;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            run_len_reg   <= '0;
            run_start_reg <= '0;
            pos_reg       <= '0;
        end
        else if (step_en)
        begin
            mode_reg      <= mode_next;
            bm_reg        <= bm_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

// File: rtl/ltl_tok_outq.sv
// Three-entry result queue: takes up to two result items per cycle, gives one.
// Depends on ltl_tok_pkg.
module ltl_tok_outq
    import ltl_tok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_push_t push,
    input  logic      pop_ready,
    output logic      room,
    output logic      head_valid,
    output tok_res_t  head
);

    localparam logic [1:0] LAST_SLOT = 2'd2;

    tok_res_t   entries_reg [3];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] wr_ptr_plus1;
    logic [1:0] wr_ptr_plus2;
    logic       pop_fire;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == LAST_SLOT) ? 2'd0 : p + 2'd1;
    endfunction

    // Room for a two-result step even if nothing leaves this cycle.
    assign room       = (count_reg <= 2'd1);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entries_reg[rd_ptr_reg];
    assign pop_fire   = head_valid && pop_ready;

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign wr_ptr_plus2 = ptr_inc(wr_ptr_plus1);

    // Pointer and occupancy update.
    always_comb
    begin
        count_next  = count_reg + push.cnt - {1'b0, pop_fire};
        rd_ptr_next = pop_fire ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wr_ptr_plus2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= push.res1;
        end
    end

endmodule

// File: rtl/ltl_formula_tokenizer_top.sv
// Top level of the LTL formula tokenizer: input register, scan core and result queue.
// Depends on ltl_tok_pkg, ltl_tok_core and ltl_tok_outq.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------------------
//   in      | in_valid / in_ready  | ch, end_of_text
//   out     | out_valid / out_ready| token_kind, number_value, number_overflow,
//           |                      | bool_value, token_start, token_length, last
//
// One character item is accepted per cycle unless the input register holds an item
// that waits for room in the result queue. An accepted item is scanned from the input
// register once the queue has room, and its results enter the queue when it is scanned.
// The three-entry result queue sets the rate: an item is scanned only while the queue
// holds at most one result, so items that give two tokens, or a stalled output,
// hold the input until the queue has drained.
// Reset clears the tokenizer state, the input register and the queue.
module ltl_formula_tokenizer_top
    import ltl_tok_pkg::*;
#(
    parameter int LENGTH_LIMIT   = LENGTH_LIMIT_DEF,
    parameter int POSITION_LIMIT = POSITION_LIMIT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           ch,
    input  logic                 end_of_text,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    token_kind,
    output logic [VALUE_W-1:0]   number_value,
    output logic                 number_overflow,
    output logic                 bool_value,
    output logic [START_W-1:0]   token_start,
    output logic [LEN_OUT_W-1:0] token_length,
    output logic                 last
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       eot_reg;
    logic       room;
    logic       step_en;
    tok_push_t  push;
    tok_res_t   head;

    // Input register: refilled whenever its item is consumed or it is empty.
    assign step_en       = in_valid_reg && room;
    assign in_ready      = !in_valid_reg || step_en;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            eot_reg <= end_of_text;
        end
    end

    // Scan core.
    ltl_tok_core #(
        .LENGTH_LIMIT   (LENGTH_LIMIT),
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .ch          (ch_reg),
        .end_of_text (eot_reg),
        .push        (push)
    );

    // Result queue.
    ltl_tok_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (out_ready),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign token_kind      = head.kind;
    assign number_value    = head.value;
    assign number_overflow = head.ovf;
    assign bool_value      = head.bval;
    assign token_start     = head.start;
    assign token_length    = head.len;
    assign last            = head.last;

    // An end item always yields at least its end token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && eot_reg) |-> (push.cnt != 2'd0))
        else $error("end item produced no result");

    // Only the final result of a step carries last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.res1.last && !push.res0.last))
        else $error("last flag misplaced on a two-result step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd1) |-> push.res0.last)
        else $error("single result of a step lacks last");

    // Nothing is pushed while the scan is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |-> (push.cnt == 2'd0))
        else $error("result pushed without a consumed item");

    // An end token closes its item and has no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind == K_END) |-> (last && token_length == '0))
        else $error("malformed end token");

endmodule
